### hdl/cavpid_pkg.sv
// ----------------------------------------------------------------------------
// cavpid_pkg: shared types and constants of the cascaded angle/velocity PID
// Item types of both channels, register indexes, sequencer codes and the
// widths of the digit-serial gain multiplier.
// ----------------------------------------------------------------------------
package cavpid_pkg;

	// Input item: one control tick.
	typedef struct packed {
		logic signed [31:0] angle_target;
		logic signed [31:0] angle_now;
		logic signed [31:0] speed_now;
	} in_item_t;

	// Result item: the drive command of one tick.
	typedef struct packed {
		logic signed [31:0] drive;
		logic               clamped;
	} out_item_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_OUTER_KP    = 3'd0;
	localparam logic [2:0] REG_OUTER_KI    = 3'd1;
	localparam logic [2:0] REG_OUTER_KD    = 3'd2;
	localparam logic [2:0] REG_INNER_KP    = 3'd3;
	localparam logic [2:0] REG_INNER_KI    = 3'd4;
	localparam logic [2:0] REG_INNER_KD    = 3'd5;
	localparam logic [2:0] REG_DRIVE_LIMIT = 3'd6;

	localparam logic signed [31:0] DRIVE_LIMIT_RESET = 32'sd786432;

	// Multiplications of one tick, in the order they run.
	localparam logic [2:0] JOB_OKP = 3'd0;
	localparam logic [2:0] JOB_OKI = 3'd1;
	localparam logic [2:0] JOB_OKD = 3'd2;
	localparam logic [2:0] JOB_IKP = 3'd3;
	localparam logic [2:0] JOB_IKI = 3'd4;
	localparam logic [2:0] JOB_IKD = 3'd5;

	// Digit-serial multiplier geometry: Q8.8 gain times a 33-bit difference.
	localparam int GAIN_W   = 16;
	localparam int DIGIT_W  = 4;
	localparam int N_DIGITS = GAIN_W / DIGIT_W;
	localparam int VAL_W    = 33;
	localparam int TERM_W   = VAL_W + DIGIT_W + 1;
	localparam int ACC_W    = 50;
	localparam int FRAC_SH  = 8;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ISSUE = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_PREP  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

endpackage

### hdl/cavpid_digit_mul.sv
// ----------------------------------------------------------------------------
// cavpid_digit_mul: digit-serial gain multiplier
// Multiplies a signed Q8.8 gain by a signed 33-bit value, four gain bits per
// cycle, most significant digit first, then floors back to Q16.16 and
// saturates to 32 bits. The result is valid with done and holds until the
// next start.
// ----------------------------------------------------------------------------
module cavpid_digit_mul (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [cavpid_pkg::GAIN_W-1:0]   gain,
	input  logic signed [cavpid_pkg::VAL_W-1:0]    value,
	output logic                                   done,
	output logic signed [31:0]                     product
);

	localparam int ACC_W  = cavpid_pkg::ACC_W;
	localparam int TERM_W = cavpid_pkg::TERM_W;
	localparam int SHR_W  = ACC_W - cavpid_pkg::FRAC_SH;
	localparam int CNT_W  = $clog2(cavpid_pkg::N_DIGITS);

	logic [cavpid_pkg::GAIN_W-1:0]         gain_sr_q;
	logic signed [cavpid_pkg::VAL_W-1:0]   val_q;
	logic signed [ACC_W-1:0]               acc_q;
	logic [CNT_W-1:0]                      cnt_q;
	logic                                  busy_q;
	logic                                  done_q;

	logic [cavpid_pkg::DIGIT_W-1:0]        nib;
	logic signed [cavpid_pkg::DIGIT_W:0]   dig;
	logic signed [TERM_W-1:0]              term;
	logic signed [ACC_W-1:0]               acc_next;
	logic signed [SHR_W-1:0]               shr;

	// The leading digit carries the sign of the gain; the others are unsigned.
	assign nib = gain_sr_q[cavpid_pkg::GAIN_W-1 -: cavpid_pkg::DIGIT_W];
	assign dig = (cnt_q == '0) ? {nib[cavpid_pkg::DIGIT_W-1], nib} : {1'b0, nib};
	assign term = dig * val_q;
	assign acc_next = (acc_q <<< cavpid_pkg::DIGIT_W)
		+ {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};

	// Control: count digits and flag completion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(cavpid_pkg::N_DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: gain shift register and Horner accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			gain_sr_q <= gain;
			val_q     <= value;
			acc_q     <= '0;
		end else if (busy_q) begin
			gain_sr_q <= gain_sr_q << cavpid_pkg::DIGIT_W;
			acc_q     <= acc_next;
		end
	end

	// Floor shift back to Q16.16 and saturate to the 32-bit range.
	assign shr = acc_q[ACC_W-1:cavpid_pkg::FRAC_SH];

	always_comb begin
		if (&shr[SHR_W-1:31] || ~|shr[SHR_W-1:31]) begin
			product = shr[31:0];
		end else if (shr[SHR_W-1]) begin
			product = 32'sh8000_0000;
		end else begin
			product = 32'sh7FFF_FFFF;
		end
	end

	assign done = done_q;

endmodule

### hdl/cascade_angle_velocity_pid.sv
// ----------------------------------------------------------------------------
// cascade_angle_velocity_pid: cascaded angle/velocity PID controller
// Each input item is one control tick (angle target, measured angle, measured
// speed) and yields one result item: the drive command, clamped above at
// drive_limit, with a flag when the clamp acted. All values are Q16.16 and
// gains Q8.8; every term, integrator and loop result saturates to 32 bits.
// Each item runs from acceptance to the loaded result in steps: the six gain
// products run one after another on a single digit-serial multiplier that
// consumes four gain bits per cycle, with an accept step before them, a prep
// step between the angle and velocity loops and an output step that loads
// the output register once the output is free. The next item is accepted as
// soon as the result is loaded, while that result may still wait to be taken.
// Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module cascade_angle_velocity_pid (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  cavpid_pkg::in_item_t   in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output cavpid_pkg::out_item_t  out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data
);

	cavpid_pkg::state_t state_q;

	logic signed [15:0] outer_kp_q, outer_ki_q, outer_kd_q;
	logic signed [15:0] inner_kp_q, inner_ki_q, inner_kd_q;
	logic signed [31:0] drive_limit_q;

	logic signed [31:0] outer_integral_q, inner_integral_q;
	logic signed [31:0] prior_angle_q, prior_speed_q;

	logic [2:0]         job_q;
	logic signed [31:0] speed_q;
	logic signed [32:0] err_q;
	logic signed [32:0] delta_q;
	logic signed [33:0] sum_q;
	logic signed [31:0] res_q;

	logic                  out_valid_q;
	cavpid_pkg::out_item_t out_data_q;

	logic               mul_start;
	logic               mul_done;
	logic signed [31:0] mul_product;
	logic signed [15:0] gain_sel;
	logic signed [32:0] value_sel;
	logic               is_d_job;

	logic signed [31:0] integ_sel;
	logic signed [31:0] integ_new;
	logic signed [31:0] total_sat;
	logic               accept;
	logic               out_load;
	logic               clamp;

	// Saturate a 34-bit signed sum to 32 bits.
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (&v[33:31] || ~|v[33:31]) begin
			return v[31:0];
		end else if (v[33]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7FFF_FFFF;
		end
	endfunction

	// Handshakes.
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != cavpid_pkg::ST_IDLE);
	assign out_load  = (state_q == cavpid_pkg::ST_OUT) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_kp_q    <= '0;
			outer_ki_q    <= '0;
			outer_kd_q    <= '0;
			inner_kp_q    <= '0;
			inner_ki_q    <= '0;
			inner_kd_q    <= '0;
			drive_limit_q <= cavpid_pkg::DRIVE_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cavpid_pkg::REG_OUTER_KP:    outer_kp_q    <= cfg_data[15:0];
				cavpid_pkg::REG_OUTER_KI:    outer_ki_q    <= cfg_data[15:0];
				cavpid_pkg::REG_OUTER_KD:    outer_kd_q    <= cfg_data[15:0];
				cavpid_pkg::REG_INNER_KP:    inner_kp_q    <= cfg_data[15:0];
				cavpid_pkg::REG_INNER_KI:    inner_ki_q    <= cfg_data[15:0];
				cavpid_pkg::REG_INNER_KD:    inner_kd_q    <= cfg_data[15:0];
				cavpid_pkg::REG_DRIVE_LIMIT: drive_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (job_q)
			cavpid_pkg::JOB_OKP: gain_sel = outer_kp_q;
			cavpid_pkg::JOB_OKI: gain_sel = outer_ki_q;
			cavpid_pkg::JOB_OKD: gain_sel = outer_kd_q;
			cavpid_pkg::JOB_IKP: gain_sel = inner_kp_q;
			cavpid_pkg::JOB_IKI: gain_sel = inner_ki_q;
			cavpid_pkg::JOB_IKD: gain_sel = inner_kd_q;
			default:             gain_sel = '0;
		endcase
	end

	assign is_d_job  = (job_q == cavpid_pkg::JOB_OKD) || (job_q == cavpid_pkg::JOB_IKD);
	assign value_sel = is_d_job ? delta_q : err_q;
	assign mul_start = (state_q == cavpid_pkg::ST_ISSUE);

	cavpid_digit_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.gain    (gain_sel),
		.value   (value_sel),
		.done    (mul_done),
		.product (mul_product)
	);

	// Integrator update and the final three-term sum of a loop.
	assign integ_sel = (job_q == cavpid_pkg::JOB_OKI) ? outer_integral_q : inner_integral_q;
	assign integ_new = sat34({{2{integ_sel[31]}}, integ_sel}
		+ {{2{mul_product[31]}}, mul_product});
	assign total_sat = sat34(sum_q + {{2{mul_product[31]}}, mul_product});
	assign clamp     = (res_q > drive_limit_q);

	// Sequencer and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= cavpid_pkg::ST_IDLE;
			job_q            <= cavpid_pkg::JOB_OKP;
			outer_integral_q <= '0;
			inner_integral_q <= '0;
			prior_angle_q    <= '0;
			prior_speed_q    <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				cavpid_pkg::ST_IDLE: begin
					if (accept) begin
						prior_angle_q <= in_data.angle_now;
						job_q         <= cavpid_pkg::JOB_OKP;
						state_q       <= cavpid_pkg::ST_ISSUE;
					end
				end
				cavpid_pkg::ST_ISSUE: begin
					state_q <= cavpid_pkg::ST_WAIT;
				end
				cavpid_pkg::ST_WAIT: begin
					if (mul_done) begin
						case (job_q) inside
							cavpid_pkg::JOB_OKD: state_q <= cavpid_pkg::ST_PREP;
							cavpid_pkg::JOB_IKD: state_q <= cavpid_pkg::ST_OUT;
							default: begin
								job_q   <= job_q + 3'd1;
								state_q <= cavpid_pkg::ST_ISSUE;
							end
						endcase
						if (job_q == cavpid_pkg::JOB_OKI) begin
							outer_integral_q <= integ_new;
						end
						if (job_q == cavpid_pkg::JOB_IKI) begin
							inner_integral_q <= integ_new;
						end
					end
				end
				cavpid_pkg::ST_PREP: begin
					prior_speed_q <= speed_q;
					job_q         <= cavpid_pkg::JOB_IKP;
					state_q       <= cavpid_pkg::ST_ISSUE;
				end
				cavpid_pkg::ST_OUT: begin
					if (out_load) begin
						state_q <= cavpid_pkg::ST_IDLE;
					end
				end
				default: state_q <= cavpid_pkg::ST_IDLE;
			endcase
		end
	end

	// Loop datapath: differences, partial sums and the loop result.
	always_ff @(posedge clk) begin
		if (accept) begin
			speed_q <= in_data.speed_now;
			err_q   <= {in_data.angle_target[31], in_data.angle_target}
				- {in_data.angle_now[31], in_data.angle_now};
			delta_q <= {in_data.angle_now[31], in_data.angle_now}
				- {prior_angle_q[31], prior_angle_q};
		end
		if (state_q == cavpid_pkg::ST_PREP) begin
			err_q   <= {res_q[31], res_q} - {speed_q[31], speed_q};
			delta_q <= {speed_q[31], speed_q} - {prior_speed_q[31], prior_speed_q};
		end
		if (state_q == cavpid_pkg::ST_WAIT && mul_done) begin
			case (job_q) inside
				cavpid_pkg::JOB_OKP, cavpid_pkg::JOB_IKP:
					sum_q <= {{2{mul_product[31]}}, mul_product};
				cavpid_pkg::JOB_OKI, cavpid_pkg::JOB_IKI:
					sum_q <= sum_q + {{2{integ_new[31]}}, integ_new};
				default:
					res_q <= total_sat;
			endcase
		end
		if (out_load) begin
			out_data_q.drive   <= clamp ? drive_limit_q : res_q;
			out_data_q.clamped <= clamp;
		end
	end

	// The multiplier reports completion only while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == cavpid_pkg::ST_WAIT)
		else $error("multiplier done outside of wait state");

	// A started product is always waited for.
	a_issue_then_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cavpid_pkg::ST_ISSUE |=> state_q == cavpid_pkg::ST_WAIT)
		else $error("issue not followed by wait");

	// A new result only appears from the output state.
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == cavpid_pkg::ST_OUT))
		else $error("result loaded outside of output state");

	// The job counter never runs past the last product of a tick.
	a_job_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_q <= cavpid_pkg::JOB_IKD)
		else $error("job counter out of range");

endmodule
